### hdl/cbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbc_pkg
// Shared types, widths and codes of the corridor bound calculator.
// ----------------------------------------------------------------------------
package cbc_pkg;

  // Field and working widths
  localparam int FIELD_W  = 24;
  localparam int MARGIN_W = 23;
  localparam int CALC_W   = 28;
  localparam int STEP_W   = 7;
  localparam int SLOT_W   = 4;

  // Configuration register widths and port form
  localparam int BASE_W     = 16;
  localparam int SLOPE_W    = 10;
  localparam int COUNT_W    = 5;
  localparam int PROD_W     = SLOPE_W + STEP_W;
  localparam int HALF_W     = PROD_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Saturation limits of an output field, at working width
  localparam logic signed [CALC_W-1:0] F_MAX = CALC_W'(2**(FIELD_W-1) - 1);
  localparam logic signed [CALC_W-1:0] F_MIN = CALC_W'(-(2**(FIELD_W-1)));

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_S_BASE  = 3'd0,
    CFG_S_SLOPE = 3'd1,
    CFG_D_BASE  = 3'd2,
    CFG_D_SLOPE = 3'd3,
    CFG_COUNT   = 3'd4
  } cfg_idx_t;

  // Request function codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

  // One obstacle table entry
  typedef struct packed {
    logic signed [FIELD_W-1:0] pos;
    logic signed [FIELD_W-1:0] lat;
    logic [MARGIN_W-1:0]       margin;
  } cbc_obs_t;

  // Evaluation result of one obstacle
  typedef struct packed {
    logic                     vld;
    logic                     hit;
    logic                     left;
    logic signed [CALC_W-1:0] cand;
  } cbc_hit_t;

  // Saturate a working value to the signed field range
  function automatic logic signed [FIELD_W-1:0] sat_field(input logic signed [CALC_W-1:0] v);
    logic signed [CALC_W-1:0] c;
    c = v;
    if (v > F_MAX) c = F_MAX;
    if (v < F_MIN) c = F_MIN;
    return c[FIELD_W-1:0];
  endfunction

endpackage

### hdl/cbc_obs_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbc_obs_table
// Obstacle table memory: one write port for load requests, one registered
// read port for the obstacle walk.
// ----------------------------------------------------------------------------
module cbc_obs_table #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  cbc_pkg::cbc_obs_t wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output cbc_pkg::cbc_obs_t rd_data,
  output logic             rd_valid
);

  cbc_pkg::cbc_obs_t mem [DEPTH];
  cbc_pkg::cbc_obs_t rd_data_r;
  logic              rd_valid_r;

  // Write one slot
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Mark read data as fresh for one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= rd_en;
    end
  end

  assign rd_data  = rd_data_r;
  assign rd_valid = rd_valid_r;

endmodule

### hdl/cbc_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbc_unit
// Obstacle evaluation unit, reused for every table entry of a walk: window
// test and clamped lateral candidate, one entry per cycle, registered.
// ----------------------------------------------------------------------------
module cbc_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_vld,
  input  cbc_pkg::cbc_obs_t                 entry,
  input  logic signed [cbc_pkg::CALC_W-1:0] slb,
  input  logic signed [cbc_pkg::CALC_W-1:0] sub,
  input  logic signed [cbc_pkg::CALC_W-1:0] pd,
  output cbc_pkg::cbc_hit_t                 res
);

  localparam int W = cbc_pkg::CALC_W;

  logic signed [W-1:0] os;
  logic signed [W-1:0] od;
  logic signed [W-1:0] r;
  logic signed [W-1:0] win_lo;
  logic signed [W-1:0] win_hi;
  logic signed [W-1:0] cand;
  logic                left;
  cbc_pkg::cbc_hit_t   res_nxt;
  cbc_pkg::cbc_hit_t   res_r;

  // Extend entry fields to working width
  assign os = W'(entry.pos);
  assign od = W'(entry.lat);
  assign r  = $signed(W'(entry.margin));

  // Widened along-path window and side of the planned offset
  assign win_lo = slb - r;
  assign win_hi = sub + r;
  assign left   = (od >= pd);
  assign cand   = left ? (od - r) : (od + r);

  // Clamp the candidate so it never crosses the planned offset
  always_comb begin
    res_nxt.vld  = in_vld;
    res_nxt.hit  = (win_lo <= os) && (os <= win_hi);
    res_nxt.left = left;
    if (left) begin
      res_nxt.cand = (cand > pd) ? cand : pd;
    end else begin
      res_nxt.cand = (cand < pd) ? cand : pd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r.vld <= 1'b0;
    end else begin
      res_r.vld <= res_nxt.vld;
    end
    res_r.hit  <= res_nxt.hit;
    res_r.left <= res_nxt.left;
    res_r.cand <= res_nxt.cand;
  end

  assign res = res_r;

endmodule

### hdl/corridor_bound_calculator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// corridor_bound_calculator_core
// Step corridor from a funnel of margins and a walk over the obstacle table.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on in_* (valid/ready). in_func selects a load request,
//   which writes one obstacle slot and gives no result, or a step request,
//   which gives one result on out_* (valid/ready).
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_wdata); the
//   user must write it while the block is idle; the block does not enforce it.
//   A load request leaves the block idle. A step request passes two setup
//   steps, the obstacle walk, two clipping steps and one output step, with
//   in_ready low meanwhile. The walk reads n table slots (obstacle_count,
//   capped at MAX_OBSTACLES), one table read per cycle into the single
//   evaluation unit; both the table read and the evaluation are registered.
//   in_ready returns high together with out_valid, so a new request can be
//   taken while a result waits. If the receiver stalls, the next step result
//   is held inside until the output register is free.
//   Reset (rst_n, synchronous) restores the register defaults and empties
//   the pipeline; the obstacle table keeps undefined contents until loaded.
// ----------------------------------------------------------------------------
module corridor_bound_calculator_core #(
  parameter int MAX_OBSTACLES = 16,
  parameter int HORIZON_STEPS = 64
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_func,
  input  logic [cbc_pkg::SLOT_W-1:0]            in_slot,
  input  logic signed [cbc_pkg::FIELD_W-1:0]    in_obstacle_s,
  input  logic signed [cbc_pkg::FIELD_W-1:0]    in_obstacle_d,
  input  logic [cbc_pkg::MARGIN_W-1:0]          in_obstacle_margin,
  input  logic [cbc_pkg::STEP_W-1:0]            in_step_index,
  input  logic signed [cbc_pkg::FIELD_W-1:0]    in_path_s,
  input  logic signed [cbc_pkg::FIELD_W-1:0]    in_path_d,
  input  logic signed [cbc_pkg::FIELD_W-1:0]    in_left_lane,
  input  logic signed [cbc_pkg::FIELD_W-1:0]    in_right_lane,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [cbc_pkg::FIELD_W-1:0]    out_s_lower,
  output logic signed [cbc_pkg::FIELD_W-1:0]    out_s_upper,
  output logic signed [cbc_pkg::FIELD_W-1:0]    out_d_lower,
  output logic signed [cbc_pkg::FIELD_W-1:0]    out_d_upper,
  input  logic                                  cfg_we,
  input  logic [cbc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [cbc_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

  localparam int W  = cbc_pkg::CALC_W;
  localparam int FW = cbc_pkg::FIELD_W;
  localparam int AW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
  localparam int NW = $clog2(MAX_OBSTACLES + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP_HALF,
    ST_SETUP_BOUND,
    ST_WALK,
    ST_CLIP_UP,
    ST_CLIP_LO,
    ST_DONE
  } state_t;

  // Configuration registers
  logic [cbc_pkg::BASE_W-1:0]  cfg_s_base_r;
  logic [cbc_pkg::SLOPE_W-1:0] cfg_s_slope_r;
  logic [cbc_pkg::BASE_W-1:0]  cfg_d_base_r;
  logic [cbc_pkg::SLOPE_W-1:0] cfg_d_slope_r;
  logic [cbc_pkg::COUNT_W-1:0] cfg_count_r;

  // Sequencer and datapath registers
  state_t                      state_r, state_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [NW-1:0]               issue_cnt_r, issue_cnt_nxt;
  logic [NW-1:0]               n_r, n_nxt;
  logic [cbc_pkg::PROD_W-1:0]  prod_s_r, prod_s_nxt;
  logic [cbc_pkg::PROD_W-1:0]  prod_d_r, prod_d_nxt;
  logic [cbc_pkg::HALF_W-1:0]  sh_r, sh_nxt;
  logic [cbc_pkg::HALF_W-1:0]  dh_r, dh_nxt;
  logic signed [W-1:0]         ps_r, ps_nxt;
  logic signed [W-1:0]         pd_r, pd_nxt;
  logic signed [W-1:0]         ll_r, ll_nxt;
  logic signed [W-1:0]         rl_r, rl_nxt;
  logic signed [W-1:0]         slb_r, slb_nxt;
  logic signed [W-1:0]         sub_r, sub_nxt;
  logic signed [W-1:0]         dlb_r, dlb_nxt;
  logic signed [W-1:0]         dub_r, dub_nxt;
  logic signed [FW-1:0]        out_s_lower_r, out_s_lower_nxt;
  logic signed [FW-1:0]        out_s_upper_r, out_s_upper_nxt;
  logic signed [FW-1:0]        out_d_lower_r, out_d_lower_nxt;
  logic signed [FW-1:0]        out_d_upper_r, out_d_upper_nxt;

  // Combinational helpers
  logic [cbc_pkg::STEP_W-1:0]  step_clamp;
  logic [NW-1:0]               n_clamp;
  logic signed [W-1:0]         sh_w;
  logic signed [W-1:0]         dh_w;
  logic signed [W-1:0]         up_floor;
  logic signed [W-1:0]         lo_ceil;
  logic                        in_acc;
  logic                        tbl_we;
  logic                        tbl_re;
  cbc_pkg::cbc_obs_t           tbl_wdata;
  cbc_pkg::cbc_obs_t           tbl_rdata;
  logic                        tbl_rvalid;
  cbc_pkg::cbc_hit_t           unit_res;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_s_base_r  <= cbc_pkg::BASE_W'(512);
      cfg_s_slope_r <= cbc_pkg::SLOPE_W'(51);
      cfg_d_base_r  <= cbc_pkg::BASE_W'(512);
      cfg_d_slope_r <= cbc_pkg::SLOPE_W'(10);
      cfg_count_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cbc_pkg::CFG_S_BASE:  cfg_s_base_r  <= cfg_wdata[cbc_pkg::BASE_W-1:0];
        cbc_pkg::CFG_S_SLOPE: cfg_s_slope_r <= cfg_wdata[cbc_pkg::SLOPE_W-1:0];
        cbc_pkg::CFG_D_BASE:  cfg_d_base_r  <= cfg_wdata[cbc_pkg::BASE_W-1:0];
        cbc_pkg::CFG_D_SLOPE: cfg_d_slope_r <= cfg_wdata[cbc_pkg::SLOPE_W-1:0];
        cbc_pkg::CFG_COUNT:   cfg_count_r   <= cfg_wdata[cbc_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Request handshake and table load
  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign tbl_we    = in_acc && (in_func == cbc_pkg::FUNC_LOAD) &&
                     (32'(in_slot) < MAX_OBSTACLES);
  assign tbl_wdata = '{pos: in_obstacle_s, lat: in_obstacle_d, margin: in_obstacle_margin};
  assign tbl_re    = (state_r == ST_WALK) && (issue_cnt_r != n_r);

  cbc_obs_table #(
    .DEPTH (MAX_OBSTACLES),
    .AW    (AW)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (tbl_we),
    .wr_addr  (AW'(in_slot)),
    .wr_data  (tbl_wdata),
    .rd_en    (tbl_re),
    .rd_addr  (issue_cnt_r[AW-1:0]),
    .rd_data  (tbl_rdata),
    .rd_valid (tbl_rvalid)
  );

  cbc_unit u_unit (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (tbl_rvalid),
    .entry  (tbl_rdata),
    .slb    (slb_r),
    .sub    (sub_r),
    .pd     (pd_r),
    .res    (unit_res)
  );

  // Clamp step and walk length
  assign step_clamp = (32'(in_step_index) > HORIZON_STEPS) ?
                      cbc_pkg::STEP_W'(HORIZON_STEPS) : in_step_index;
  assign n_clamp    = (32'(cfg_count_r) > MAX_OBSTACLES) ?
                      NW'(MAX_OBSTACLES) : NW'(cfg_count_r);
  assign sh_w       = $signed(W'(sh_r));
  assign dh_w       = $signed(W'(dh_r));
  assign up_floor   = ll_r - dh_w;
  assign lo_ceil    = rl_r + dh_w;

  // Sequencer
  always_comb begin
    state_nxt       = state_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    issue_cnt_nxt   = issue_cnt_r;
    n_nxt           = n_r;
    prod_s_nxt      = prod_s_r;
    prod_d_nxt      = prod_d_r;
    sh_nxt          = sh_r;
    dh_nxt          = dh_r;
    ps_nxt          = ps_r;
    pd_nxt          = pd_r;
    ll_nxt          = ll_r;
    rl_nxt          = rl_r;
    slb_nxt         = slb_r;
    sub_nxt         = sub_r;
    dlb_nxt         = dlb_r;
    dub_nxt         = dub_r;
    out_s_lower_nxt = out_s_lower_r;
    out_s_upper_nxt = out_s_upper_r;
    out_d_lower_nxt = out_d_lower_r;
    out_d_upper_nxt = out_d_upper_r;

    unique case (state_r)
      ST_IDLE: begin
        // Capture a step request and form the slope products
        if (in_acc && (in_func == cbc_pkg::FUNC_STEP)) begin
          ps_nxt        = W'(in_path_s);
          pd_nxt        = W'(in_path_d);
          ll_nxt        = W'(in_left_lane);
          rl_nxt        = W'(in_right_lane);
          prod_s_nxt    = cbc_pkg::PROD_W'(cfg_s_slope_r) * cbc_pkg::PROD_W'(step_clamp);
          prod_d_nxt    = cbc_pkg::PROD_W'(cfg_d_slope_r) * cbc_pkg::PROD_W'(step_clamp);
          n_nxt         = n_clamp;
          issue_cnt_nxt = '0;
          state_nxt     = ST_SETUP_HALF;
        end
      end
      ST_SETUP_HALF: begin
        // Funnel half widths
        sh_nxt    = cbc_pkg::HALF_W'(cfg_s_base_r) + cbc_pkg::HALF_W'(prod_s_r);
        dh_nxt    = cbc_pkg::HALF_W'(cfg_d_base_r) + cbc_pkg::HALF_W'(prod_d_r);
        state_nxt = ST_SETUP_BOUND;
      end
      ST_SETUP_BOUND: begin
        slb_nxt   = ps_r - sh_w;
        sub_nxt   = ps_r + sh_w;
        dlb_nxt   = pd_r - dh_w;
        dub_nxt   = pd_r + dh_w;
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        // Issue one slot per cycle, fold each evaluated obstacle into the bounds
        if (tbl_re) begin
          issue_cnt_nxt = issue_cnt_r + NW'(1);
        end
        if (unit_res.vld && unit_res.hit) begin
          if (unit_res.left) begin
            if (unit_res.cand < dub_r) dub_nxt = unit_res.cand;
          end else begin
            if (unit_res.cand > dlb_r) dlb_nxt = unit_res.cand;
          end
        end
        if (!tbl_re && !tbl_rvalid && !unit_res.vld) begin
          state_nxt = ST_CLIP_UP;
        end
      end
      ST_CLIP_UP: begin
        // Clip to the left lane, reopen downward if too narrow
        if (dub_r > ll_r) begin
          dub_nxt = ll_r;
          if (up_floor < dlb_r) dlb_nxt = up_floor;
        end
        state_nxt = ST_CLIP_LO;
      end
      ST_CLIP_LO: begin
        // Clip to the right lane, reopen upward if too narrow
        if (dlb_r < rl_r) begin
          dlb_nxt = rl_r;
          if (dub_r < lo_ceil) dub_nxt = lo_ceil;
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // Hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_s_lower_nxt = cbc_pkg::sat_field(slb_r);
          out_s_upper_nxt = cbc_pkg::sat_field(sub_r);
          out_d_lower_nxt = cbc_pkg::sat_field(dlb_r);
          out_d_upper_nxt = cbc_pkg::sat_field(dub_r);
          out_valid_nxt   = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      issue_cnt_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      issue_cnt_r <= issue_cnt_nxt;
    end
    n_r           <= n_nxt;
    prod_s_r      <= prod_s_nxt;
    prod_d_r      <= prod_d_nxt;
    sh_r          <= sh_nxt;
    dh_r          <= dh_nxt;
    ps_r          <= ps_nxt;
    pd_r          <= pd_nxt;
    ll_r          <= ll_nxt;
    rl_r          <= rl_nxt;
    slb_r         <= slb_nxt;
    sub_r         <= sub_nxt;
    dlb_r         <= dlb_nxt;
    dub_r         <= dub_nxt;
    out_s_lower_r <= out_s_lower_nxt;
    out_s_upper_r <= out_s_upper_nxt;
    out_d_lower_r <= out_d_lower_nxt;
    out_d_upper_r <= out_d_upper_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_s_lower = out_s_lower_r;
  assign out_s_upper = out_s_upper_r;
  assign out_d_lower = out_d_lower_r;
  assign out_d_upper = out_d_upper_r;

  // Checks
  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_func == cbc_pkg::FUNC_LOAD) && !out_valid_r |=> !out_valid_r)
    else $error("load request produced a result");

  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (issue_cnt_r <= n_r))
    else $error("walk issued past the active slot count");

  a_unit_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    unit_res.vld |-> (state_r == ST_WALK))
    else $error("obstacle result left the walk");

  a_bounds_hold_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLIP_UP) |-> ((dlb_r <= pd_r) && (dub_r >= pd_r)))
    else $error("lateral bound crossed the planned offset");

endmodule
